// ===== src/matrix_multiply_4x4_assert.svh =====
// Assertion macros for the matrix multiply block.
// Used by the top level; needs no other file.
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MM4_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm4 assertion failed");

// Next-cycle implication, checked out of reset.
`define MM4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm4 assertion failed");

`endif

// ===== src/mm4_pkg.sv =====
// Shared types and constants of the matrix multiply block.
// No dependencies; used by the controller, datapath and top level.
package mm4_pkg;

  localparam int unsigned ELEM_W = 32;  // Q16.16 element
  localparam int unsigned PROD_W = 64;  // exact product of two elements
  localparam int unsigned IDX_W  = 4;   // product index field

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;     // store the input word
    logic wr_right;  // 1: right matrix store, 0: left
    logic rd_en;     // read one A/B pair for the dot product
    logic first;     // first term of a dot product
    logic last_k;    // last term of a dot product
    logic out_load;  // move finished sum into the output register
    logic out_last;  // this sum is the final element of the matrix
  } mm4_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_done;  // finished sum waiting in the accumulator
    logic out_free;  // output register can take a word this cycle
  } mm4_status_t;

endpackage

// ===== src/mm4_ctrl.sv =====
// Controller of the matrix multiply block: load counter and the
// row/column/term sequencer. Uses mm4_pkg.
module mm4_ctrl #(
  parameter int unsigned DIM = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    element_valid_i,
  output logic                    element_ready_o,
  input  mm4_pkg::mm4_status_t    status_i,
  output mm4_pkg::mm4_cmd_t       cmd_o,
  output logic [$clog2(DIM*DIM)-1:0] wr_addr_o,
  output logic [$clog2(DIM*DIM)-1:0] a_addr_o,
  output logic [$clog2(DIM*DIM)-1:0] b_addr_o,
  output logic [mm4_pkg::IDX_W-1:0]  out_idx_o
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned LOADS = 2 * CELLS;
  localparam int unsigned CW    = $clog2(CELLS);
  localparam int unsigned LW    = $clog2(LOADS);
  localparam int unsigned IW    = $clog2(DIM);
  localparam logic [IW-1:0] LAST_I = IW'(DIM - 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] load_cnt_q, load_cnt_d;
  logic [IW-1:0] row_q, row_d;
  logic [IW-1:0] col_q, col_d;
  logic [IW-1:0] k_q, k_d;
  logic          accept;
  logic          last_cell;

  assign element_ready_o = (state_q == ST_LOAD);
  assign accept          = element_valid_i && element_ready_o;
  assign last_cell       = (row_q == LAST_I) && (col_q == LAST_I);

  // Store and read addresses
  assign wr_addr_o = (load_cnt_q < LW'(CELLS)) ? load_cnt_q[CW-1:0]
                                               : CW'(load_cnt_q - LW'(CELLS));
  assign a_addr_o  = CW'(int'(row_q) * DIM + int'(k_q));
  assign b_addr_o  = CW'(int'(k_q) * DIM + int'(col_q));
  assign out_idx_o = mm4_pkg::IDX_W'(int'(row_q) * DIM + int'(col_q));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_right = (load_cnt_q >= LW'(CELLS));
          if (load_cnt_q == LW'(LOADS - 1)) begin
            load_cnt_d = '0;
            row_d      = '0;
            col_d      = '0;
            k_d        = '0;
            state_d    = ST_ISSUE;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.first  = (k_q == '0);
        cmd_o.last_k = (k_q == LAST_I);
        if (k_q == LAST_I) begin
          k_d     = '0;
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status_i.acc_done && status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = last_cell;
          if (last_cell) begin
            state_d = ST_LOAD;
          end else if (col_q == LAST_I) begin
            col_d   = '0;
            row_d   = row_q + 1'b1;
            state_d = ST_ISSUE;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
    end
  end

endmodule

// ===== src/mm4_datapath.sv =====
// Datapath of the matrix multiply block: A/B stores, one shared multiplier,
// accumulator, shift/saturate and the output register. Uses mm4_pkg.
module mm4_datapath #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [mm4_pkg::ELEM_W-1:0]  element_value_i,
  input  mm4_pkg::mm4_cmd_t                  cmd_i,
  input  logic [$clog2(DIM*DIM)-1:0]         wr_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]         a_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]         b_addr_i,
  input  logic [mm4_pkg::IDX_W-1:0]          out_idx_i,
  output mm4_pkg::mm4_status_t               status_o,
  output logic                               product_valid_o,
  input  logic                               product_ready_i,
  output logic signed [mm4_pkg::ELEM_W-1:0]  product_value_o,
  output logic [mm4_pkg::IDX_W-1:0]          product_index_o,
  output logic                               last_of_run_o
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned EW    = mm4_pkg::ELEM_W;
  localparam int unsigned PW    = mm4_pkg::PROD_W;
  localparam int unsigned ACC_W = PW + $clog2(DIM);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  // Element stores
  logic signed [EW-1:0] left_mem  [CELLS];
  logic signed [EW-1:0] right_mem [CELLS];
  logic signed [EW-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_right) begin
      left_mem[wr_addr_i] <= element_value_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= left_mem[a_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_right) begin
      right_mem[wr_addr_i] <= element_value_i;
    end
    if (cmd_i.rd_en) begin
      b_rd_q <= right_mem[b_addr_i];
    end
  end

  // Pipeline tags for the read and multiply stages
  logic rd_vld_q, rd_first_q, rd_last_q;
  logic mul_vld_q, mul_first_q, mul_last_q;
  logic acc_done_q, acc_done_d;
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      acc_done_q  <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.rd_en;
      rd_first_q  <= cmd_i.first;
      rd_last_q   <= cmd_i.last_k;
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
      acc_done_q  <= acc_done_d;
    end
  end

  // Multiply, then accumulate at full width
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= PW'(a_rd_q) * PW'(b_rd_q);
    end
  end

  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    acc_d      = acc_q;
    acc_done_d = acc_done_q;
    if (mul_vld_q) begin
      acc_d = mul_first_q ? prod_ext : acc_q + prod_ext;
      if (mul_last_q) begin
        acc_done_d = 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      acc_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Floor shift and saturation into the output word
  logic signed [ACC_W-1:0] shifted;
  logic signed [EW-1:0]    sat_value;

  assign shifted = acc_q >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_value = {1'b0, {(EW - 1){1'b1}}};
    end else if (shifted < SAT_MIN) begin
      sat_value = {1'b1, {(EW - 1){1'b0}}};
    end else begin
      sat_value = shifted[EW-1:0];
    end
  end

  // Output register
  logic signed [EW-1:0]          out_value_q;
  logic [mm4_pkg::IDX_W-1:0]     out_idx_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (product_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= sat_value;
      out_idx_q   <= out_idx_i;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign status_o.acc_done = acc_done_q;
  assign status_o.out_free = !out_valid_q || product_ready_i;

  assign product_valid_o = out_valid_q;
  assign product_value_o = out_value_q;
  assign product_index_o = out_idx_q;
  assign last_of_run_o   = out_last_q;

endmodule

// ===== src/matrix_multiply_4x4.sv =====
// Top level of the fixed-point matrix multiply; instantiates mm4_ctrl and
// mm4_datapath, uses mm4_pkg and matrix_multiply_4x4_assert.svh.
//
// Send 2*DIM*DIM signed Q16.16 words: matrix A row-major, then matrix B
// row-major, one word per cycle while element_ready_o is high. After the
// last word of B the block computes C = A*B with one shared 32x32 multiplier
// and returns the DIM*DIM words of C row-major, each with its index and with
// last_of_run_o set on the final one. Every dot product is summed exactly,
// floored by FRAC_BITS and saturated to 32 bits. Each product word is
// formed in order: DIM issue steps, each reading one A/B pair from the
// stores, then the multiply stage, the accumulate stage and the hand-off
// into the output register, before the next word is started. Input is not
// taken while C is being formed; loading of the next pair starts while the
// last word of C still waits in the output register.
module matrix_multiply_4x4 #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              element_valid_i,
  output logic                              element_ready_o,
  input  logic signed [mm4_pkg::ELEM_W-1:0] element_value_i,
  output logic                              product_valid_o,
  input  logic                              product_ready_i,
  output logic signed [mm4_pkg::ELEM_W-1:0] product_value_o,
  output logic [mm4_pkg::IDX_W-1:0]         product_index_o,
  output logic                              last_of_run_o
);

  localparam int unsigned CW = $clog2(DIM * DIM);

  mm4_pkg::mm4_cmd_t           cmd;
  mm4_pkg::mm4_status_t        status;
  logic [CW-1:0]               wr_addr;
  logic [CW-1:0]               a_addr;
  logic [CW-1:0]               b_addr;
  logic [mm4_pkg::IDX_W-1:0]   out_idx;

  mm4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_valid_i (element_valid_i),
    .element_ready_o (element_ready_o),
    .status_i        (status),
    .cmd_o           (cmd),
    .wr_addr_o       (wr_addr),
    .a_addr_o        (a_addr),
    .b_addr_o        (b_addr),
    .out_idx_o       (out_idx)
  );

  mm4_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .wr_addr_i       (wr_addr),
    .a_addr_i        (a_addr),
    .b_addr_i        (b_addr),
    .out_idx_i       (out_idx),
    .status_o        (status),
    .product_valid_o (product_valid_o),
    .product_ready_i (product_ready_i),
    .product_value_o (product_value_o),
    .product_index_o (product_index_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Checks
  `include "matrix_multiply_4x4_assert.svh"

  // a word only moves to the output when its sum is done and the slot is free
  `MM4_ASSERT_NOW(a_out_load_ok, clk_i, rst_ni, cmd.out_load, status.acc_done && status.out_free)
  // no store reads and no finished sum waiting while loading
  `MM4_ASSERT_NOW(a_no_read_in_load, clk_i, rst_ni, element_ready_o, !cmd.rd_en && !status.acc_done)
  // after the final word of C the block is ready for a new load
  `MM4_ASSERT_NEXT(a_back_to_load, clk_i, rst_ni, cmd.out_load && cmd.out_last, element_ready_o)

endmodule
